@@ sv/toom_pkg.sv @@
// Shared types and constants of the TCP option order matcher.
// No dependencies; compiled first.
package toom_pkg;

	localparam int WordW     = 64;
	localparam int FieldBits = 3;
	localparam int FieldCount = 22;
	localparam int PosW      = 5;
	localparam int NumCodes  = 4;
	localparam int ClassW    = 2;

	localparam logic [FieldBits-1:0] FieldMask = 3'h7;

	// Option codes that take part in the ordering check
	localparam logic [FieldBits-1:0] CodeMss  = 3'd1;
	localparam logic [FieldBits-1:0] CodeSack = 3'd4;

	// Result classes
	localparam logic [ClassW-1:0] ClassViolated = 2'd0;
	localparam logic [ClassW-1:0] ClassInOrder  = 2'd1;
	localparam logic [ClassW-1:0] ClassIdentical = 2'd2;

	// Token that travels down the cell chain
	typedef struct packed {
		logic [WordW-1:0]                 rest;      // target fields not yet checked
		logic [NumCodes-1:0]              found;     // code present in signature
		logic [NumCodes-1:0][PosW-1:0]    pos;       // first signature position per code
		logic                             identical;
		logic                             have_mark;
		logic [PosW-1:0]                  mark;
		logic                             violated;
	} tok_t;

endpackage

@@ sv/toom_if.sv @@
// Valid/ready channel interfaces for the option order matcher.
// Depends on toom_pkg.
interface toom_in_if;
	import toom_pkg::*;

	logic             valid;
	logic             ready;
	logic [WordW-1:0] target_options;
	logic [WordW-1:0] signature_options;

	modport source (output valid, output target_options, output signature_options, input ready);
	modport sink   (input valid, input target_options, input signature_options, output ready);
endinterface

interface toom_out_if;
	import toom_pkg::*;

	logic              valid;
	logic              ready;
	logic [ClassW-1:0] match_class;

	modport source (output valid, output match_class, input ready);
	modport sink   (input valid, input match_class, output ready);
endinterface

@@ sv/tcp_option_order_matcher_core.sv @@
// TCP option order matcher: grades two packed option lists by ordering.
// Channels on toom_in_if / toom_out_if; locate stage feeds a chain of 22 cells.
// Depends on toom_pkg, toom_if.sv, toom_locate, toom_cell.
//
// Usage:
//   item   : valid/ready input; one transfer carries target_options and
//            signature_options (64 bits each, 3-bit codes from the LSB).
//   result : valid/ready output; one transfer per item carries match_class
//            (2 identical, 1 in order, 0 order violated).
// There are 23 register stages: one stage locates the first signature
// position of each of the four codes, then one cell per target field
// (22 fields) checks that field against the running mark.
// One item is accepted per cycle while the receiver does not stall; every
// stage holds its own item, so up to 23 items are in flight.
// When the receiver stalls, each stage holds its token and ready falls back
// stage by stage; empty stages keep filling until the chain is full.
// Reset clears the valid flag of every stage; no item is in flight after it.
module tcp_option_order_matcher_core (
	input  logic      clk,
	input  logic      arst_n,
	toom_in_if.sink   item,
	toom_out_if.source result
);
	import toom_pkg::*;

	logic chain_valid [FieldCount+1];
	logic chain_ready [FieldCount+1];
	tok_t chain_tok   [FieldCount+1];
	tok_t last_tok;

	toom_locate u_locate (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.target    (item.target_options),
		.signature (item.signature_options),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_tok   (chain_tok[0])
	);

	// One cell per target field
	for (genvar k = 0; k < FieldCount; k++) begin : g_cell
		toom_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[k]),
			.in_ready  (chain_ready[k]),
			.in_tok    (chain_tok[k]),
			.out_valid (chain_valid[k+1]),
			.out_ready (chain_ready[k+1]),
			.out_tok   (chain_tok[k+1])
		);
	end

	assign last_tok                = chain_tok[FieldCount];
	assign result.valid            = chain_valid[FieldCount];
	assign chain_ready[FieldCount] = result.ready;

	// Grade the finished token
	always_comb begin
		priority if (last_tok.identical) begin
			result.match_class = ClassIdentical;
		end else if (last_tok.violated) begin
			result.match_class = ClassViolated;
		end else begin
			result.match_class = ClassInOrder;
		end
	end
endmodule

@@ sv/toom_locate.sv @@
// Head stage: finds the first signature position of each important code.
// Depends on toom_pkg.
module toom_locate (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [toom_pkg::WordW-1:0]    target,
	input  logic [toom_pkg::WordW-1:0]    signature,
	output logic                          out_valid,
	input  logic                          out_ready,
	output toom_pkg::tok_t                out_tok
);
	import toom_pkg::*;

	localparam int PadW = FieldBits * FieldCount;

	logic [PadW-1:0] sig_pad;
	tok_t            tok_d;
	logic            valid_s1;
	tok_t            tok_s1;

	assign sig_pad = {{(PadW - WordW){1'b0}}, signature};

	// Priority search from the top so the lowest match wins
	always_comb begin
		tok_d           = '0;
		tok_d.rest      = target;
		tok_d.identical = (target == signature);
		for (int c = 0; c < NumCodes; c++) begin
			for (int j = FieldCount - 1; j >= 0; j--) begin
				if (sig_pad[j*FieldBits +: FieldBits] == (CodeMss + FieldBits'(c))) begin
					tok_d.found[c] = 1'b1;
					tok_d.pos[c]   = PosW'(j);
				end
			end
		end
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_tok   = tok_s1;

	// Advance on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tok_s1 <= tok_d;
		end
	end
endmodule

@@ sv/toom_cell.sv @@
// One cell of the order-check chain: checks one target field, then hands on.
// Depends on toom_pkg.
module toom_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  toom_pkg::tok_t in_tok,
	output logic           out_valid,
	input  logic           out_ready,
	output toom_pkg::tok_t out_tok
);
	import toom_pkg::*;

	logic [FieldBits-1:0]        code;
	logic [$clog2(NumCodes)-1:0] idx;
	logic                        important;
	logic                        hit;
	tok_t                        tok_d;
	logic                        valid_q;
	tok_t                        tok_q;

	assign code      = in_tok.rest[FieldBits-1:0] & FieldMask;
	assign important = (code >= CodeMss) && (code <= CodeSack);
	assign idx       = $clog2(NumCodes)'(code - CodeMss);
	assign hit       = important && in_tok.found[idx];

	// Move the mark, flag a step backward
	always_comb begin
		tok_d      = in_tok;
		tok_d.rest = in_tok.rest >> FieldBits;
		if (hit) begin
			if (in_tok.have_mark && (in_tok.pos[idx] < in_tok.mark)) begin
				tok_d.violated = 1'b1;
			end
			tok_d.mark      = in_tok.pos[idx];
			tok_d.have_mark = 1'b1;
		end
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_tok   = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tok_q <= tok_d;
		end
	end
endmodule
